// ===== src/rnc_pkg.sv =====
// ----------------------------------------------------------------------------
// rnc_pkg
// shared types, constants and numeral tables for the roman numeral converter
// ----------------------------------------------------------------------------
package rnc_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [11:0] ValueMax = 12'd3999;
  localparam logic [12:0] TotalCap = 13'd4000;

  localparam logic [0:0] ModeEncode = 1'b0;
  localparam logic [0:0] ModeDecode = 1'b1;

  localparam logic [7:0] CharNone = 8'h00;
  localparam logic [7:0] CharI    = 8'h49;
  localparam logic [7:0] CharV    = 8'h56;
  localparam logic [7:0] CharX    = 8'h58;
  localparam logic [7:0] CharL    = 8'h4c;
  localparam logic [7:0] CharC    = 8'h43;
  localparam logic [7:0] CharD    = 8'h44;
  localparam logic [7:0] CharM    = 8'h4d;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] number_in;
    logic [7:0]         char_in;
    logic               final_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  char_out;
    logic [11:0] number_out;
    logic        error;
    logic        end_of_run;
  } result_t;

  // work handed from the front part to the back part
  typedef struct packed {
    logic        is_enc;
    logic        err;
    logic [11:0] value;
  } cmd_t;

  function automatic logic [9:0] letter_value(input logic [7:0] c);
    logic [9:0] v;
    unique case (c)
      CharI:   v = 10'd1;
      CharV:   v = 10'd5;
      CharX:   v = 10'd10;
      CharL:   v = 10'd50;
      CharC:   v = 10'd100;
      CharD:   v = 10'd500;
      CharM:   v = 10'd1000;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

  function automatic logic pair_allowed(input logic [9:0] lo, input logic [9:0] hi);
    logic ok;
    unique case (lo)
      10'd1:   ok = (hi == 10'd5)   || (hi == 10'd10);
      10'd10:  ok = (hi == 10'd50)  || (hi == 10'd100);
      10'd100: ok = (hi == 10'd500) || (hi == 10'd1000);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [9:0] enc_value(input logic [3:0] idx);
    logic [9:0] v;
    unique case (idx)
      4'd0:    v = 10'd1000;
      4'd1:    v = 10'd900;
      4'd2:    v = 10'd500;
      4'd3:    v = 10'd400;
      4'd4:    v = 10'd100;
      4'd5:    v = 10'd90;
      4'd6:    v = 10'd50;
      4'd7:    v = 10'd40;
      4'd8:    v = 10'd10;
      4'd9:    v = 10'd9;
      4'd10:   v = 10'd5;
      4'd11:   v = 10'd4;
      default: v = 10'd1;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] enc_first(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = CharM;
      4'd1:    c = CharC;
      4'd2:    c = CharD;
      4'd3:    c = CharC;
      4'd4:    c = CharC;
      4'd5:    c = CharX;
      4'd6:    c = CharL;
      4'd7:    c = CharX;
      4'd8:    c = CharX;
      4'd9:    c = CharI;
      4'd10:   c = CharV;
      default: c = CharI;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] enc_second(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd1:    c = CharM;
      4'd3:    c = CharD;
      4'd5:    c = CharC;
      4'd7:    c = CharL;
      4'd9:    c = CharX;
      4'd11:   c = CharV;
      default: c = CharNone;
    endcase
    return c;
  endfunction

  // largest table entry not above rem; independent compares, highest wins
  function automatic logic [3:0] greedy_index(input logic [11:0] rem);
    logic [3:0] idx;
    idx = 4'd12;
    for (int i = 12; i >= 0; i--) begin
      if (rem >= {2'b00, enc_value(4'(i))}) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== src/roman_numeral_converter.sv =====
// ----------------------------------------------------------------------------
// roman_numeral_converter
// integer to roman numeral encoder and streaming numeral decoder
// ----------------------------------------------------------------------------
// mode 0 items carry an integer; 1..3999 comes back as numeral characters,
// one beat each, at most 15, last one flagged end_of_run; anything else gives
// one error beat. mode 1 items carry one numeral character each; only the
// beat marked final_char produces a result: the value, or an error for a bad
// letter, a non-standard subtractive pair or a total outside 1..3999. encode
// items may be mixed into a numeral being decoded. the front part takes one
// item per cycle while the two-entry command queue has room; the back part
// emits one result beat per cycle while its output is free or popped, so an
// encode gives one beat per numeral character and a decode result one beat.
// ----------------------------------------------------------------------------
module roman_numeral_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item side
  input  logic              push,
  output logic              full,
  input  rnc_pkg::in_item_t item_i,
  // result side
  output logic              empty,
  input  logic              pop,
  output rnc_pkg::result_t  result_o
);

  logic          cmd_push, cmd_pop, cmd_valid, q_full;
  rnc_pkg::cmd_t cmd_in, cmd_out;

  assign full = q_full;

  // front: classify items, keep decode state, queue up work
  rnc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .q_full_i   (q_full),
    .item_i     (item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // decoupling queue so each side can stall on its own
  rnc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  // back: one result beat per cycle, while the output is free or popped, into a registered output
  rnc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

// ===== src/rnc_front.sv =====
// ----------------------------------------------------------------------------
// rnc_front
// accepts items, range checks encodes, folds decode characters into the total
// ----------------------------------------------------------------------------
module rnc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              q_full_i,
  input  rnc_pkg::in_item_t item_i,
  output logic              cmd_push_o,
  output rnc_pkg::cmd_t     cmd_o
);

  logic [9:0]  pend_q, pend_d;
  logic [11:0] total_q, total_d;
  logic        err_q, err_d;

  logic        accept;
  logic [9:0]  w;
  logic [11:0] tot1, tot2, pend_step;
  logic        err1;
  logic        bad;

  function automatic logic [11:0] sat_add(input logic [11:0] t, input logic [9:0] x);
    logic [12:0] s;
    s = {1'b0, t} + {3'b000, x};
    return (s > rnc_pkg::TotalCap) ? rnc_pkg::TotalCap[11:0] : s[11:0];
  endfunction

  assign accept = push_i && !q_full_i;
  assign w      = rnc_pkg::letter_value(item_i.char_in);

  always_comb begin
    pend_step = {2'b00, pend_q};
    tot1      = total_q;
    err1      = err_q;
    if (!err_q) begin
      if (w == 10'd0) begin
        err1 = 1'b1;
      end else if (pend_q == 10'd0) begin
        pend_step = {2'b00, w};
      end else if (w > pend_q) begin
        if (rnc_pkg::pair_allowed(pend_q, w)) begin
          tot1      = sat_add(total_q, w - pend_q);
          pend_step = 12'd0;
        end else begin
          err1 = 1'b1;
        end
      end else begin
        tot1      = sat_add(total_q, pend_q);
        pend_step = {2'b00, w};
      end
    end
    // final character adds whatever letter is still pending
    tot2 = tot1;
    if (!err1 && pend_step != 12'd0) begin
      tot2 = sat_add(tot1, pend_step[9:0]);
    end
    bad = err1 || (tot2 == 12'd0) || (tot2 > rnc_pkg::ValueMax);
  end

  always_comb begin
    pend_d     = pend_q;
    total_d    = total_q;
    err_d      = err_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    if (accept) begin
      if (item_i.mode == rnc_pkg::ModeEncode) begin
        cmd_push_o = 1'b1;
        if (item_i.number_in < 16'sd1 || item_i.number_in > 16'sd3999) begin
          cmd_o.err = 1'b1;
        end else begin
          cmd_o.is_enc = 1'b1;
          cmd_o.value  = item_i.number_in[11:0];
        end
      end else if (item_i.final_char) begin
        cmd_push_o  = 1'b1;
        cmd_o.err   = bad;
        cmd_o.value = bad ? 12'd0 : tot2;
        pend_d      = '0;
        total_d     = '0;
        err_d       = 1'b0;
      end else begin
        pend_d  = pend_step[9:0];
        total_d = tot1;
        err_d   = err1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      total_q <= '0;
      err_q   <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      total_q <= total_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== src/rnc_queue.sv =====
// ----------------------------------------------------------------------------
// rnc_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module rnc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rnc_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output rnc_pkg::cmd_t data_o
);

  rnc_pkg::cmd_t                     mem_q [rnc_pkg::QueueDepth];
  logic [rnc_pkg::QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [rnc_pkg::QueueCntW-1:0]     count_q;
  logic                              do_push, do_pop;

  assign full_o  = (count_q == rnc_pkg::QueueCntW'(rnc_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == rnc_pkg::QueuePtrW'(rnc_pkg::QueueDepth - 1)) ? '0
                    : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == rnc_pkg::QueuePtrW'(rnc_pkg::QueueDepth - 1)) ? '0
                    : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/rnc_back.sv =====
// ----------------------------------------------------------------------------
// rnc_back
// runs commands: greedy numeral emission, or a single value/error beat
// ----------------------------------------------------------------------------
module rnc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  rnc_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output rnc_pkg::result_t result_o
);

  rnc_pkg::result_t res_q, res_d;
  logic             valid_q, valid_d;
  logic             busy_q, busy_d;
  logic             sec_pend_q, sec_pend_d;
  logic [7:0]       sec_char_q, sec_char_d;
  logic [11:0]      rem_q, rem_d;

  logic        out_ready;
  logic [11:0] cur, new_rem;
  logic [3:0]  idx;
  logic [7:0]  sec;

  assign out_ready = !valid_q || pop_i;
  assign cur       = busy_q ? rem_q : cmd_i.value;
  assign idx       = rnc_pkg::greedy_index(cur);
  assign new_rem   = cur - {2'b00, rnc_pkg::enc_value(idx)};
  assign sec       = rnc_pkg::enc_second(idx);

  always_comb begin
    res_d      = res_q;
    valid_d    = valid_q;
    busy_d     = busy_q;
    sec_pend_d = sec_pend_q;
    sec_char_d = sec_char_q;
    rem_d      = rem_q;
    cmd_pop_o  = 1'b0;
    if (out_ready) begin
      valid_d = 1'b0;
      if (sec_pend_q) begin
        res_d      = '{char_out: sec_char_q, number_out: 12'd0, error: 1'b0,
                       end_of_run: (rem_q == 12'd0)};
        valid_d    = 1'b1;
        sec_pend_d = 1'b0;
        busy_d     = (rem_q != 12'd0);
      end else if (busy_q || (cmd_valid_i && cmd_i.is_enc)) begin
        res_d      = '{char_out: rnc_pkg::enc_first(idx), number_out: 12'd0, error: 1'b0,
                       end_of_run: (new_rem == 12'd0) && (sec == rnc_pkg::CharNone)};
        valid_d    = 1'b1;
        rem_d      = new_rem;
        sec_pend_d = (sec != rnc_pkg::CharNone);
        sec_char_d = sec;
        busy_d     = (new_rem != 12'd0) || (sec != rnc_pkg::CharNone);
        cmd_pop_o  = !busy_q;
      end else if (cmd_valid_i) begin
        res_d     = '{char_out: rnc_pkg::CharNone, number_out: cmd_i.value,
                      error: cmd_i.err, end_of_run: 1'b1};
        valid_d   = 1'b1;
        cmd_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    rem_q      <= rem_d;
    sec_char_q <= sec_char_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      busy_q     <= 1'b0;
      sec_pend_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      busy_q     <= busy_d;
      sec_pend_q <= sec_pend_d;
    end
  end

  assign empty_o  = !valid_q;
  assign result_o = res_q;

endmodule
